[rtl/ipv4lpm_pkg.sv]
`timescale 1ns / 1ps

package ipv4lpm_pkg;

    localparam int DEF_ENTRIES = 16;

    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 2;
    localparam int SLOT_W  = 4;

    // Input item: entry_slot, entry_valid, entry_prefix, entry_netmask,
    // entry_next_hop, entry_port, lookup_address, padded to whole bytes
    localparam int S_FIELDS_W = SLOT_W + 1 + 3 * ADDR_W + PORT_W + ADDR_W;
    localparam int S_DATA_W   = ((S_FIELDS_W + 7) / 8) * 8;

    // Result item: hit, next_hop, out_port, winning_slot
    localparam int M_FIELDS_W = 1 + ADDR_W + PORT_W + SLOT_W;
    localparam int M_DATA_W   = ((M_FIELDS_W + 7) / 8) * 8;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    typedef struct packed {
        logic [ADDR_W-1:0] prefix;
        logic [ADDR_W-1:0] netmask;
        logic [ADDR_W-1:0] next_hop;
        logic [PORT_W-1:0] port;
    } route_t;

endpackage

[rtl/ipv4_longest_prefix_route_lookup.sv]
`timescale 1ns / 1ps

// IPv4 longest-prefix route lookup.
// Input channel s_*: one item per command. s_tuser selects the command
// (write a table slot, or look up lookup_address). s_tdata carries the entry
// fields and the address. Result channel m_*: exactly one item per command,
// in order. Writes return an all-zero result.
// A write goes straight to the final state, from which its result is loaded
// into the output register. A lookup walks the route memory one slot per cycle
// through its single registered read port, then passes a drain state for the
// compare of the last slot, and only then reaches the final state.
// One command is processed at a time: the next item is taken only after the
// result of the last one has been loaded into the output register.
// The output register holds a finished result while the receiver stalls;
// the block returns to accepting the next item as soon as that result has
// been loaded, and a later result waits in its final state until the
// register frees up.
// Reset (aresetn low, synchronous) clears all slot valid bits, the
// sequencer and the output valid at once; no clearing pass is needed.
// The route contents of a slot are defined only once it has been written.
module ipv4_longest_prefix_route_lookup #(
    parameter int ENTRIES = ipv4lpm_pkg::DEF_ENTRIES
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // [3:0] entry_slot, [4] entry_valid, [36:5] entry_prefix,
    // [68:37] entry_netmask, [100:69] entry_next_hop, [102:101] entry_port,
    // [134:103] lookup_address, [135] zero
    input  logic [ipv4lpm_pkg::S_DATA_W-1:0] s_tdata,
    // [0] command
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [0] hit, [32:1] next_hop, [34:33] out_port, [38:35] winning_slot,
    // [39] zero
    output logic [ipv4lpm_pkg::M_DATA_W-1:0] m_tdata
);
    import ipv4lpm_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    // Unpack the input item
    logic [SLOT_W-1:0] in_slot;
    logic              in_valid;
    route_t            in_route;
    logic [ADDR_W-1:0] in_addr;

    assign in_slot           = s_tdata[SLOT_W-1:0];
    assign in_valid          = s_tdata[SLOT_W];
    assign in_route.prefix   = s_tdata[SLOT_W+1 +: ADDR_W];
    assign in_route.netmask  = s_tdata[SLOT_W+1+ADDR_W +: ADDR_W];
    assign in_route.next_hop = s_tdata[SLOT_W+1+2*ADDR_W +: ADDR_W];
    assign in_route.port     = s_tdata[SLOT_W+1+3*ADDR_W +: PORT_W];
    assign in_addr           = s_tdata[SLOT_W+1+3*ADDR_W+PORT_W +: ADDR_W];

    logic [1:0]         state_reg, state_next;
    logic [IDX_W-1:0]   rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0]  addr_reg, addr_next;
    logic [ENTRIES-1:0] valid_reg, valid_next;

    // Compare stage, aligned with the registered memory read
    logic               cmp_vld_reg;
    logic               cmp_live_reg;
    logic [IDX_W-1:0]   cmp_idx_reg;
    route_t             rd_data_reg;

    logic [ADDR_W-1:0]  best_mask_reg, best_mask_next;
    logic [IDX_W-1:0]   best_idx_reg, best_idx_next;
    logic [ADDR_W-1:0]  best_hop_reg, best_hop_next;
    logic [PORT_W-1:0]  best_port_reg, best_port_next;

    logic               m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic               s_fire;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_idx;
    logic               slot_in_range;
    logic               match;
    logic               out_free;
    logic               best_hit;

    route_t             route_mem [ENTRIES];

    assign s_tready      = (state_reg == ST_IDLE);
    assign s_fire        = s_tvalid && s_tready;
    assign slot_in_range = (32'(in_slot) < ENTRIES);
    assign wr_idx        = IDX_W'(in_slot);
    assign wr_en         = s_fire && (s_tuser == CMD_WRITE) && slot_in_range && in_valid;
    assign out_free      = !m_tvalid_reg || m_tready;
    assign best_hit      = (best_mask_reg != '0);

    // Strictly greater mask replaces, so ties keep the lowest slot
    assign match = cmp_vld_reg && cmp_live_reg
                && ((addr_reg & rd_data_reg.netmask) == rd_data_reg.prefix)
                && (rd_data_reg.netmask > best_mask_reg);

    always_comb begin
        state_next     = state_reg;
        rd_idx_next    = rd_idx_reg;
        addr_next      = addr_reg;
        valid_next     = valid_reg;
        best_mask_next = best_mask_reg;
        best_idx_next  = best_idx_reg;
        best_hop_next  = best_hop_reg;
        best_port_next = best_port_reg;
        m_tvalid_next  = m_tvalid_reg && !m_tready;
        m_tdata_next   = m_tdata_reg;

        if (match) begin
            best_mask_next = rd_data_reg.netmask;
            best_idx_next  = cmp_idx_reg;
            best_hop_next  = rd_data_reg.next_hop;
            best_port_next = rd_data_reg.port;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    best_mask_next = '0;
                    best_idx_next  = '0;
                    best_hop_next  = '0;
                    best_port_next = '0;
                    addr_next      = in_addr;
                    rd_idx_next    = '0;
                    if (s_tuser == CMD_LOOKUP) begin
                        state_next = ST_SCAN;
                    end else begin
                        // Removing a slot drops only its valid bit
                        if (slot_in_range) begin
                            valid_next[wr_idx] = in_valid;
                        end
                        state_next = ST_DONE;
                    end
                end
            end
            ST_SCAN: begin
                rd_idx_next = rd_idx_reg + 1'b1;
                if (rd_idx_reg == LAST_IDX) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                state_next = ST_DONE;
            end
            ST_DONE: begin
                // Hold the result until the output register frees up
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = '0;
                    if (best_hit) begin
                        m_tdata_next[0]                     = 1'b1;
                        m_tdata_next[1 +: ADDR_W]           = best_hop_reg;
                        m_tdata_next[1+ADDR_W +: PORT_W]    = best_port_reg;
                        m_tdata_next[1+ADDR_W+PORT_W +: SLOT_W] = SLOT_W'(best_idx_reg);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            valid_reg    <= '0;
            cmp_vld_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            valid_reg    <= valid_next;
            cmp_vld_reg  <= (state_reg == ST_SCAN);
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_idx_reg    <= rd_idx_next;
        addr_reg      <= addr_next;
        cmp_idx_reg   <= rd_idx_reg;
        cmp_live_reg  <= valid_reg[rd_idx_reg];
        best_mask_reg <= best_mask_next;
        best_idx_reg  <= best_idx_next;
        best_hop_reg  <= best_hop_next;
        best_port_reg <= best_port_next;
        m_tdata_reg   <= m_tdata_next;
    end

    // Route memory: one write port, one registered read port. Only one
    // command is in flight, so a write always lands before the next scan.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            route_mem[wr_idx] <= in_route;
        end
        rd_data_reg <= route_mem[rd_idx_reg];
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // A result held under stall is neither dropped nor changed
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result lost or changed");

    // A miss carries all-zero fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[M_DATA_W-1:1] == '0)
        else $error("miss result with nonzero fields");

    // A finished result waits while the output register is occupied
    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DONE && !out_free |=> state_reg == ST_DONE)
        else $error("result left its final state without being loaded");

    // Only one command at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> !s_tready)
        else $error("second item accepted while one is in flight");

endmodule
